// File: hdl/rlist_pkg.sv
`default_nettype none

package rlist_pkg;

    localparam int RL_MAX_ENTRIES = 16;
    localparam int RL_HANDLE_BITS = 32;

    localparam int CAP_W     = 5;
    localparam int CAP_MAX   = (1 << CAP_W) - 1;
    localparam int CAP_RESET = 16;
    localparam int IDX_W     = 8;
    localparam int PORT_HW   = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [PORT_HW-1:0] item_handle;
        logic [IDX_W-1:0]   index;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [PORT_HW-1:0] removed_handle;
        logic               evicted;
        logic [PORT_HW-1:0] evicted_handle;
        logic [CAP_W-1:0]   entry_count;
    } rsp_t;

    typedef logic [CAP_W-1:0] cap_t;

    // shift command broadcast along the cell chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
    } ctrl_t;

endpackage

`default_nettype wire

// File: hdl/rlist_stream_if.sv
`default_nettype none

interface rlist_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rlist_cell.sv
`default_nettype none

module rlist_cell
    import rlist_pkg::*;
#(
    parameter int IDX = 0,
    parameter int HB  = RL_HANDLE_BITS
) (
    input  wire logic          clk,
    input  wire ctrl_t         ctrl,
    input  wire logic [HB-1:0] prev_h,
    input  wire logic [HB-1:0] next_h,
    output logic      [HB-1:0] slot,
    output logic      [HB-1:0] tap
);

    localparam logic [IDX_W-1:0] POS = IDX_W'(IDX);

    logic [HB-1:0] slot_reg;
    logic          hit;

    assign hit  = (ctrl.pos == POS);
    assign slot = slot_reg;
    assign tap  = hit ? slot_reg : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            slot_reg <= prev_h;
        end
        else if (ctrl.rem && (ctrl.pos <= POS))
        begin
            slot_reg <= next_h;
        end
    end

endmodule

`default_nettype wire

// File: hdl/recency_list_insert_front_remove_at_core.sv
// Result registered on accept. Throughput: one transaction per cycle unless rsp
// stalls; an insert shifts every cell of the slot chain, a remove those from the
// index on, all in the same cycle; one slot is read through a single tap select.
// Reset: entry count 0, capacity 16; slot contents undefined, no clearing pass.
// A capacity write empties the list.
`default_nettype none

module recency_list_insert_front_remove_at_core
    import rlist_pkg::*;
#(
    parameter int MAX_ENTRIES = RL_MAX_ENTRIES,
    parameter int HANDLE_BITS = RL_HANDLE_BITS
) (
    input wire logic     clk,
    input wire logic     rst_n,
    rlist_stream_if.sink   req,
    rlist_stream_if.source rsp,
    rlist_stream_if.sink   cfg
);

    // capacity register cannot reach beyond CAP_MAX, so later slots are never used
    localparam int USED  = (MAX_ENTRIES < CAP_MAX) ? MAX_ENTRIES : CAP_MAX;
    localparam int CNT_W = $clog2(USED + 1);

    cap_t             cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CNT_W-1:0]       ecap;
    logic                   full;
    logic                   idx_ok;
    logic                   accept;
    logic                   cfg_accept;
    logic                   is_insert;
    ctrl_t                  ctrl;
    logic [HANDLE_BITS-1:0] in_h;
    logic [HANDLE_BITS-1:0] slots [USED];
    logic [HANDLE_BITS-1:0] taps  [USED];
    logic [HANDLE_BITS-1:0] tap_sel;

    assign req.ready  = !out_valid_reg || rsp.ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = rsp_reg;

    assign accept     = req.valid && req.ready;
    assign cfg_accept = cfg.valid && cfg.ready;
    assign is_insert  = (req.data.kind == KIND_INSERT);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            ecap = CNT_W'(1);
        end
        else if (cap_reg > CAP_W'(USED))
        begin
            ecap = CNT_W'(USED);
        end
        else
        begin
            ecap = CNT_W'(cap_reg);
        end
    end

    assign full   = (count_reg == ecap);
    assign idx_ok = (req.data.index < IDX_W'(count_reg));
    assign in_h   = HANDLE_BITS'(req.data.item_handle);

    assign ctrl.ins = accept && is_insert;
    assign ctrl.rem = accept && !is_insert && idx_ok;
    assign ctrl.pos = is_insert ? IDX_W'(ecap - CNT_W'(1)) : req.data.index;

    for (genvar i = 0; i < USED; i++)
    begin : g_cell
        logic [HANDLE_BITS-1:0] prev_h;
        logic [HANDLE_BITS-1:0] next_h;

        if (i == 0)
        begin : g_first
            assign prev_h = in_h;
        end
        else
        begin : g_mid
            assign prev_h = slots[i-1];
        end

        if (i == USED - 1)
        begin : g_last
            assign next_h = slots[i];
        end
        else
        begin : g_inner
            assign next_h = slots[i+1];
        end

        rlist_cell #(
            .IDX (i),
            .HB  (HANDLE_BITS)
        ) u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .prev_h (prev_h),
            .next_h (next_h),
            .slot   (slots[i]),
            .tap    (taps[i])
        );
    end

    always_comb
    begin
        tap_sel = '0;
        for (int i = 0; i < USED; i++)
        begin
            tap_sel = tap_sel | taps[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cfg_accept)
        begin
            count_next = '0;
        end
        else if (ctrl.ins)
        begin
            count_next = full ? ecap : count_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next.status         = (accept && !is_insert && !idx_ok) ? STATUS_BAD_INDEX
                                                                    : STATUS_OK;
        rsp_next.removed_handle = ctrl.rem ? PORT_HW'(tap_sel) : '0;
        rsp_next.evicted        = ctrl.ins && full;
        rsp_next.evicted_handle = (ctrl.ins && full) ? PORT_HW'(tap_sel) : '0;
        rsp_next.entry_count    = CAP_W'(count_next);
    end

    assign out_valid_next = accept || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(CAP_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                cap_reg <= cfg.data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ecap)
        else $error("entry count above capacity");

    a_bad_index_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_insert && !idx_ok) |=> (count_reg == $past(count_reg)))
        else $error("failed remove changed entry count");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_reg.evicted) |-> (rsp_reg.entry_count == CAP_W'(ecap)))
        else $error("eviction reported while list not full");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (rsp_reg.status == STATUS_BAD_INDEX))
            |-> (rsp_reg.removed_handle == '0 && !rsp_reg.evicted))
        else $error("failed remove returned a handle");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import rlist_pkg::*;
();

    logic clk;
    logic rst_n;

    rlist_stream_if #(.payload_t(req_t)) req_if ();
    rlist_stream_if #(.payload_t(rsp_t)) rsp_if ();
    rlist_stream_if #(.payload_t(cap_t)) cfg_if ();

    recency_list_insert_front_remove_at_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // MRU list mirror
    logic [PORT_HW-1:0] mru_slots [RL_MAX_ENTRIES];
    int                 mru_len;
    cap_t               mru_cap;
    rsp_t               mru_outcomes_q [$];

    int idle_pct;
    int errors;
    int n_insert;
    int n_remove;
    int n_evict;
    int n_bad_index;
    int n_cap_write;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rsp_t mru_update(input req_t r);
        rsp_t        o;
        int unsigned lim;
        int          i;
        o = '0;
        lim = (mru_cap == 0) ? 1 : ((mru_cap > RL_MAX_ENTRIES) ? RL_MAX_ENTRIES : mru_cap);
        if (mru_len > lim)
            mru_len = lim;
        if (r.kind == KIND_INSERT)
        begin
            if (mru_len >= lim)
            begin
                o.evicted = 1'b1;
                o.evicted_handle = mru_slots[lim-1];
                mru_len = lim - 1;
            end
            for (i = mru_len; i > 0; i--)
                mru_slots[i] = mru_slots[i-1];
            mru_slots[0] = r.item_handle;
            mru_len++;
        end
        else if (r.index >= mru_len)
        begin
            o.status = STATUS_BAD_INDEX;
        end
        else
        begin
            o.status = STATUS_OK;
            o.removed_handle = mru_slots[r.index];
            for (i = r.index; i + 1 < mru_len; i++)
                mru_slots[i] = mru_slots[i+1];
            mru_len--;
        end
        o.entry_count = CAP_W'(mru_len);
        return o;
    endfunction

    task automatic cmp_field(input string fname, input logic [PORT_HW-1:0] exp_v,
                             input logic [PORT_HW-1:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
        end
    endtask

    // transaction monitor: config, request prediction, result check
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                mru_cap = cfg_if.data;
                mru_len = 0;
                n_cap_write++;
            end
            if (req_if.valid && req_if.ready)
            begin
                want = mru_update(req_if.data);
                mru_outcomes_q.push_back(want);
                if (req_if.data.kind == KIND_INSERT)
                    n_insert++;
                else
                    n_remove++;
                if (want.evicted)
                    n_evict++;
                if (want.status == STATUS_BAD_INDEX)
                    n_bad_index++;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (mru_outcomes_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, rsp_if.data);
                end
                else
                begin
                    want = mru_outcomes_q.pop_front();
                    cmp_field("status", PORT_HW'(want.status),
                              PORT_HW'(rsp_if.data.status));
                    cmp_field("removed_handle", want.removed_handle,
                              rsp_if.data.removed_handle);
                    cmp_field("evicted", PORT_HW'(want.evicted),
                              PORT_HW'(rsp_if.data.evicted));
                    cmp_field("evicted_handle", want.evicted_handle,
                              rsp_if.data.evicted_handle);
                    cmp_field("entry_count", PORT_HW'(want.entry_count),
                              PORT_HW'(rsp_if.data.entry_count));
                end
            end
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_op(input logic k, input logic [PORT_HW-1:0] h,
                           input logic [IDX_W-1:0] ix);
        req_t r;
        r.kind = k;
        r.item_handle = h;
        r.index = ix;
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic drain_all();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (mru_outcomes_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cap(input cap_t v);
        drain_all();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_ops(input int n);
        int                 roll;
        logic [PORT_HW-1:0] h;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            h = $urandom();
            if ($urandom_range(15) == 0)
                h = $urandom_range(1) ? '1 : '0;
            if (roll < 50)
                send_op(KIND_INSERT, h, IDX_W'($urandom_range(255)));
            else if (roll < 88)
                send_op(KIND_REMOVE, h,
                        IDX_W'(mru_len > 0 ? $urandom_range(mru_len - 1) : 0));
            else
                send_op(KIND_REMOVE, h, IDX_W'($urandom_range(255)));
        end
    endtask

    task automatic test_fill_and_evict();
        logic [PORT_HW-1:0] h;
        send_op(KIND_REMOVE, '1, '0);
        for (int i = 0; i < 17; i++)
        begin
            h = (i == 0) ? '1 : (i == 1) ? '0 : {8'(i), 24'hC35A96};
            send_op(KIND_INSERT, h, '1);
        end
    endtask

    task automatic test_remove_positions();
        drain_all();
        send_op(KIND_REMOVE, '1, '0);
        send_op(KIND_REMOVE, '0, IDX_W'(RL_MAX_ENTRIES - 2));
        send_op(KIND_REMOVE, '0, IDX_W'(6));
        send_op(KIND_REMOVE, '0, IDX_W'(RL_MAX_ENTRIES - 3));
        send_op(KIND_REMOVE, '0, '1);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        random_ops(100);
        idle_pct = 32;
    endtask

    task automatic test_capacity_sweep();
        cap_t caps [8];
        caps = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd16, 5'd0, 5'd0};
        caps[6] = cap_t'($urandom_range(3, 15));
        caps[7] = cap_t'($urandom_range(31));
        foreach (caps[c])
        begin
            write_cap(caps[c]);
            random_ops(30);
            if (c == 3)
                drain_all();
            random_ops(30);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        idle_pct = 32;
        errors = 0;
        n_insert = 0;
        n_remove = 0;
        n_evict = 0;
        n_bad_index = 0;
        n_cap_write = 0;
        mru_len = 0;
        mru_cap = cap_t'(CAP_RESET);
        foreach (mru_slots[i])
            mru_slots[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_remove_positions();
        test_no_idle();
        test_capacity_sweep();

        drain_all();
        repeat (4) @(posedge clk);
        $display("covered %0d inserts with %0d evictions, %0d removes with %0d out of range",
                 n_insert, n_evict, n_remove, n_bad_index);
        $display("over %0d capacity writes incl. zero, one, full and saturated", n_cap_write);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
hdl/rlist_pkg.sv
hdl/rlist_stream_if.sv
hdl/rlist_cell.sv
hdl/recency_list_insert_front_remove_at_core.sv
tb/tb_top.sv
